/* rtl/tama_pkg.sv */
package tama_pkg;

   // width of the window length register
   localparam int REG_BITS = 11;
   // width of every result field
   localparam int OUT_BITS = 16;
   // window length after reset
   localparam int WINDOW_RESET = 16;
   localparam int AXES = 3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* rtl/tama_store.sv */
module tama_store #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 48,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tama_div.sv */
// Signed by unsigned restoring divider, one quotient bit per cycle.
// The quotient magnitude is known to fit in QUO_BITS, so only that many
// steps run; the remainder starts from the dividend bits above them.
module tama_div
   import tama_pkg::*;
#(
   parameter int SUM_W    = 26,
   parameter int QUO_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_W-1:0]    dividend,
   input  logic [REG_BITS-1:0]        divisor,
   output div_status_type             status,
   output logic signed [QUO_BITS-1:0] quotient
);

   localparam int REM_W = REG_BITS + 1;
   localparam int CNT_W = $clog2(QUO_BITS + 1);

   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [QUO_BITS-1:0] dvd_ff, dvd_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [REG_BITS-1:0] dsr_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [SUM_W-1:0] mag;
   logic [REM_W-1:0] trial;
   logic             fits;

   always_comb begin
      mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      trial = {rem_ff[REM_W-2:0], dvd_ff[QUO_BITS-1]};
      fits  = (trial >= {1'b0, dsr_ff});

      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = REM_W'(mag >> QUO_BITS);
         dvd_in  = mag[QUO_BITS-1:0];
         quo_in  = '0;
         cnt_in  = CNT_W'(QUO_BITS);
         neg_in  = dividend[SUM_W-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - {1'b0, dsr_ff}) : trial;
         dvd_in = {dvd_ff[QUO_BITS-2:0], 1'b0};
         quo_in = {quo_ff[QUO_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = neg_ff ? $signed(-quo_ff) : $signed(quo_ff);

endmodule

/* rtl/three_axis_moving_average.sv */
// Channel  | Dir | Handshake          | Payload
// req      | in  | req_tvalid/tready  | req_tdata: sample_x, sample_y, sample_z
// rsp      | out | rsp_tvalid/tready  | rsp_tdata: raw_x..z, mean_x..z
// csr      | in  | csr_valid/ready    | csr_data: window_length
//
// A fill-phase item passes through accept and store write. A full-window item
// passes through accept, store update and then the divider: the shared
// divider produces one mean bit per cycle, axis by axis. The next item is taken
// while a result waits in the output register; a second finished result stalls
// on rsp_tready. Window writes are taken only between items and hold off req.
// Reset is synchronous: length 16 (capped at MAX_WINDOW), fill restarts; fill writes each slot first.
module three_axis_moving_average
   import tama_pkg::*;
#(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,

   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // sample_x, sample_y, sample_z from bit 0 up, zero padded to bytes
   input  logic [((AXES * SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,

   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // raw_x, raw_y, raw_z, mean_x, mean_y, mean_z from bit 0 up
   output logic [2 * AXES * OUT_BITS - 1:0] rsp_tdata,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [REG_BITS-1:0] csr_data
);

   localparam int AW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W     = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
   localparam int WORD_W    = AXES * SAMPLE_BITS;
   localparam int LEN_RESET = (MAX_WINDOW < WINDOW_RESET) ? MAX_WINDOW : WINDOW_RESET;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FILL,
      S_UPDATE,
      S_DIV_START,
      S_DIV_WAIT,
      S_DONE
   } state_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]       sum_type;

   state_type           state_ff;
   logic [REG_BITS-1:0] window_length_ff;
   logic [REG_BITS-1:0] fill_count_ff;
   logic [AW-1:0]       oldest_slot_ff;
   logic [1:0]          axis_ff;
   sum_type             sum_ff  [AXES];
   sample_type          samp_ff [AXES];
   sample_type          mean_ff [AXES];
   logic                rsp_tvalid_ff;
   logic [2 * AXES * OUT_BITS - 1:0] rsp_tdata_ff;

   logic [REG_BITS-1:0]       len_in;
   logic [WORD_W-1:0]         old_word;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [31:0]               slot_next;
   sum_type                   div_dividend;
   div_status_type            div_status;
   logic signed [SAMPLE_BITS-1:0] div_quotient;
   logic                      rsp_free;
   logic                      req_fire;
   logic                      csr_fire;

   // a pending window write takes priority over the next item
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == S_IDLE);
   assign csr_fire   = csr_valid && csr_ready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      len_in = csr_data;
      if (csr_data == '0) begin
         len_in = REG_BITS'(1);
      end else if (32'(csr_data) > 32'(MAX_WINDOW)) begin
         len_in = REG_BITS'(MAX_WINDOW);
      end
   end

   assign wr_en     = (state_ff == S_FILL) || (state_ff == S_UPDATE);
   assign wr_addr   = (state_ff == S_FILL) ? AW'(fill_count_ff) : oldest_slot_ff;
   assign slot_next = 32'(oldest_slot_ff) + 32'd1;

   tama_store #(
      .DEPTH (MAX_WINDOW),
      .WIDTH (WORD_W),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({samp_ff[2], samp_ff[1], samp_ff[0]}),
      .rd_addr (oldest_slot_ff),
      .rd_data (old_word)
   );

   always_comb begin
      case (axis_ff)
         2'd0:    div_dividend = sum_ff[0];
         2'd1:    div_dividend = sum_ff[1];
         default: div_dividend = sum_ff[2];
      endcase
   end

   tama_div #(
      .SUM_W    (SUM_W),
      .QUO_BITS (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DIV_START),
      .dividend (div_dividend),
      .divisor  (window_length_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         window_length_ff <= REG_BITS'(LEN_RESET);
         fill_count_ff    <= '0;
         oldest_slot_ff   <= '0;
         axis_ff          <= '0;
         rsp_tvalid_ff    <= 1'b0;
         for (int a = 0; a < AXES; a++) begin
            sum_ff[a] <= '0;
         end
      end else begin
         if ((state_ff == S_DONE) && rsp_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         if (csr_fire) begin
            window_length_ff <= len_in;
            fill_count_ff    <= '0;
            oldest_slot_ff   <= '0;
            for (int a = 0; a < AXES; a++) begin
               sum_ff[a] <= '0;
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  for (int a = 0; a < AXES; a++) begin
                     samp_ff[a] <= req_tdata[a * SAMPLE_BITS +: SAMPLE_BITS];
                  end
                  state_ff <= (fill_count_ff < window_length_ff) ? S_FILL : S_UPDATE;
               end
            end
            S_FILL: begin
               for (int a = 0; a < AXES; a++) begin
                  sum_ff[a] <= sum_ff[a] + SUM_W'(samp_ff[a]);
               end
               fill_count_ff <= fill_count_ff + 1'b1;
               state_ff      <= S_IDLE;
            end
            S_UPDATE: begin
               // old sample of the slot being overwritten came from the read
               // issued in the accept cycle
               for (int a = 0; a < AXES; a++) begin
                  sum_ff[a] <= sum_ff[a] + SUM_W'(samp_ff[a])
                               - SUM_W'($signed(old_word[a * SAMPLE_BITS +: SAMPLE_BITS]));
               end
               oldest_slot_ff <= (slot_next >= 32'(window_length_ff)) ? '0 : AW'(slot_next);
               axis_ff        <= '0;
               state_ff       <= S_DIV_START;
            end
            S_DIV_START: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_status.done) begin
                  mean_ff[axis_ff] <= div_quotient;
                  if (axis_ff == 2'(AXES - 1)) begin
                     state_ff <= S_DONE;
                  end else begin
                     axis_ff  <= axis_ff + 1'b1;
                     state_ff <= S_DIV_START;
                  end
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_tdata_ff  <= {OUT_BITS'(mean_ff[2]), OUT_BITS'(mean_ff[1]),
                                    OUT_BITS'(mean_ff[0]), OUT_BITS'(samp_ff[2]),
                                    OUT_BITS'(samp_ff[1]), OUT_BITS'(samp_ff[0])};
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= window_length_ff)
      else $error("fill count beyond window length");

   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      32'(oldest_slot_ff) < 32'(window_length_ff))
      else $error("oldest slot outside window");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == S_DIV_WAIT)
      else $error("divider finished outside wait state");

   a_csr_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> fill_count_ff == '0)
      else $error("window length write did not restart fill");

endmodule
